// ===== src/ias_pkg.sv =====
package ias_pkg;

	localparam int INDEX_W  = 10;
	localparam int LIMIT_W  = 11;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_DUP   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_EXEC  = 3'b010,
		S_SWEEP = 3'b100
	} fsm_t;

endpackage

// ===== src/index_allocator_free_stack_unit.sv =====
// Index allocator with a LIFO free stack. For each transaction (allocate, free
// or clear) the accept cycle reads the stack top and the membership bit of
// index_to_free from their RAMs; the next cycle decides and writes stack and
// bitmap back as the operation needs. The result then shows on done for one
// cycle, and busy is low by then unless the operation was a clear, so a new
// transaction can start while done is high. The receiver cannot stall; done is
// never held. After reset and every clear the membership bitmap is zeroed by a
// sweep of all its entries with busy high; a clear's own result arrives at the
// normal time. The limit register may be written at any time the block is idle.
module index_allocator_free_stack_unit
	import ias_pkg::*;
#(
	parameter int MAX_INDICES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [OP_W-1:0]     operation,
	input  logic [INDEX_W-1:0]  index_to_free,
	input  logic                cfg_we,
	input  logic [LIMIT_W-1:0]  cfg_wdata,
	output logic                done,
	output logic [INDEX_W-1:0]  allocated_index,
	output logic [STATUS_W-1:0] status
);

	// only indices below 1024 can ever be pushed, so storage caps there
	localparam int DEPTH = (MAX_INDICES < 1024) ? MAX_INDICES : 1024;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam logic [LIMIT_W-1:0] LIM_CAP =
		LIMIT_W'((MAX_INDICES < 2047) ? MAX_INDICES : 2047);
	localparam logic [CW-1:0] COUNT_MAX = CW'(DEPTH);
	localparam logic [AW-1:0] SWEEP_LAST = AW'(DEPTH - 1);

	fsm_t                 state_q;
	logic [LIMIT_W-1:0]   cfg_q;
	logic [CW-1:0]        count_q;
	logic [LIMIT_W-1:0]   fresh_q;
	logic [AW-1:0]        sweep_q;
	op_t                  op_s1;
	logic [INDEX_W-1:0]   idx_s1;
	logic                 done_q;
	logic [INDEX_W-1:0]   index_q;
	status_t              status_q;

	logic                 accept;
	logic [LIMIT_W-1:0]   lim;
	logic [CW-1:0]        count_dec;
	logic                 stk_we;
	logic [INDEX_W-1:0]   stk_rdata;
	logic                 bm_we;
	logic [AW-1:0]        bm_waddr;
	logic [0:0]           bm_wdata;
	logic [0:0]           bm_rdata;
	logic                 idx_in_range;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign lim       = (cfg_q > LIM_CAP) ? LIM_CAP : cfg_q;
	assign count_dec = count_q - CW'(1);
	assign idx_in_range = ({1'b0, idx_s1} < lim);

	ias_ram #(.WIDTH(INDEX_W), .DEPTH(DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (count_q[AW-1:0]),
		.wdata (idx_s1),
		.re    (accept),
		.raddr (count_dec[AW-1:0]),
		.rdata (stk_rdata)
	);

	ias_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_bitmap (
		.clk   (clk),
		.we    (bm_we),
		.waddr (bm_waddr),
		.wdata (bm_wdata),
		.re    (accept),
		.raddr (index_to_free[AW-1:0]),
		.rdata (bm_rdata)
	);

	// write-back decisions in the execute cycle, and the bitmap writes of the sweep
	always_comb begin
		stk_we   = 1'b0;
		bm_we    = 1'b0;
		bm_waddr = sweep_q;
		bm_wdata = 1'b0;
		if (state_q == S_SWEEP) begin
			bm_we = 1'b1;
		end else if (state_q == S_EXEC) begin
			case (op_s1)
				OP_ALLOC: begin
					if (count_q != '0) begin
						bm_we    = 1'b1;
						bm_waddr = stk_rdata[AW-1:0];
					end
				end
				OP_FREE: begin
					if (idx_in_range && !bm_rdata[0]) begin
						stk_we   = 1'b1;
						bm_we    = 1'b1;
						bm_waddr = idx_s1[AW-1:0];
						bm_wdata = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			cfg_q   <= LIMIT_RESET;
			count_q <= '0;
			fresh_q <= '0;
			sweep_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					case (op_s1)
						OP_ALLOC: begin
							if (count_q != '0) begin
								count_q <= count_dec;
							end else if (fresh_q < lim) begin
								fresh_q <= fresh_q + LIMIT_W'(1);
							end
						end
						OP_FREE: begin
							if (idx_in_range && !bm_rdata[0]) begin
								count_q <= count_q + CW'(1);
							end
						end
						OP_CLEAR: begin
							count_q <= '0;
							fresh_q <= '0;
							sweep_q <= '0;
							state_q <= S_SWEEP;
						end
						default: ;
					endcase
				end
				S_SWEEP: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == SWEEP_LAST) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= op_t'(operation);
			idx_s1 <= index_to_free;
		end
		if (state_q == S_EXEC) begin
			index_q  <= '0;
			status_q <= ST_OK;
			case (op_s1)
				OP_ALLOC: begin
					if (count_q != '0) begin
						index_q <= stk_rdata;
					end else if (fresh_q < lim) begin
						index_q <= fresh_q[INDEX_W-1:0];
					end else begin
						status_q <= ST_EMPTY;
					end
				end
				OP_FREE: begin
					if (!idx_in_range) begin
						status_q <= ST_RANGE;
					end else if (bm_rdata[0]) begin
						status_q <= ST_DUP;
					end
				end
				default: ;
			endcase
		end
	end

	assign done            = done_q;
	assign allocated_index = index_q;
	assign status          = status_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_MAX)
		else $error("free stack count above depth");

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= LIM_CAP)
		else $error("fresh index above limit cap");

	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |=> done_q)
		else $error("execute cycle without result");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_EXEC))
		else $error("result strobe without execute cycle");

	a_fail_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q != ST_OK)) |-> (index_q == '0))
		else $error("nonzero index on failed transaction");
`endif

endmodule

// ===== src/ias_ram.sv =====
module ias_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
